/* hw/rtl/wpp_pkg.sv */
// Package for the WAV PCM header parser: tag constants, status codes and the
// structs passed between the parser modules. No dependencies.
`default_nettype none

package wpp_pkg;

   localparam int unsigned MIN_FILE_BYTES_DEFAULT = 44;

   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] CHUNK_HEADER_BYTES = 32'd8;
   localparam logic [31:0] FMT_MIN_BYTES      = 32'd16;
   localparam logic [15:0] FORMAT_PCM         = 16'd1;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_SHORT       = 3'd1,
      STATUS_BAD_TAG     = 3'd2,
      STATUS_NOT_PCM     = 3'd3,
      STATUS_MISSING     = 3'd4,
      STATUS_UNSUPPORTED = 3'd5
   } wpp_status_type;

   typedef struct packed {
      logic take;
      logic form;
   } wpp_ctrl_type;

   typedef struct packed {
      logic [31:0] length;
      logic        tag_error;
      logic        fmt_not_pcm;
      logic        fmt_valid;
      logic [15:0] channels;
      logic [31:0] rate;
      logic [15:0] bits;
      logic        data_found;
      logic [31:0] data_offset;
      logic [31:0] data_size;
   } wpp_summary_type;

endpackage

`default_nettype wire

/* hw/rtl/wpp_req_if.sv */
// Input channel of the WAV PCM header parser: one file byte per transaction.
// No dependencies.
`default_nettype none

interface wpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       end_of_file;

   modport source (output valid, output file_byte, output end_of_file, input ready);
   modport sink (input valid, input file_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

/* hw/rtl/wpp_rsp_if.sv */
// Result channel of the WAV PCM header parser: one summary per file.
// No dependencies.
`default_nettype none

interface wpp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] channel_count;
   logic [30:0] sample_rate;
   logic [15:0] bits_per_sample;
   logic [1:0]  format_code;
   logic [31:0] data_offset;
   logic [31:0] data_size;

   modport source (output valid, output status, output channel_count, output sample_rate,
                   output bits_per_sample, output format_code, output data_offset,
                   output data_size, input ready);
   modport sink (input valid, input status, input channel_count, input sample_rate,
                 input bits_per_sample, input format_code, input data_offset,
                 input data_size, output ready);
endinterface

`default_nettype wire

/* hw/rtl/wpp_byte_parser.sv */
// Byte-level RIFF/WAVE chunk walker: updates the parse state once per byte.
// Depends on wpp_pkg.
`default_nettype none

module wpp_byte_parser import wpp_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire wpp_ctrl_type    ctrl,
   input  wire logic [7:0]      file_byte,
   input  wire logic            end_of_file,
   output wpp_summary_type      summary,
   output logic                 final_pending
);

   typedef enum logic [4:0] {
      PHASE_RIFF = 5'b00001,
      PHASE_CHDR = 5'b00010,
      PHASE_BODY = 5'b00100,
      PHASE_PAD  = 5'b01000,
      PHASE_HALT = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      KIND_OTHER = 2'd0,
      KIND_FMT   = 2'd1,
      KIND_DATA  = 2'd2
   } kind_type;

   logic        final_ff, final_in;
   logic [31:0] pos_ff, pos_in;
   phase_type   phase_ff, phase_in;
   logic        tag_error_ff, tag_error_in;
   logic        not_pcm_ff, not_pcm_in;
   logic        fmt_valid_ff, fmt_valid_in;
   logic        data_found_ff, data_found_in;

   logic [63:0] shift_ff, shift_in;
   logic [31:0] remain_ff, remain_in;
   kind_type    kind_ff, kind_in;
   logic [4:0]  body_idx_ff, body_idx_in;
   logic [31:0] chunk_len_ff, chunk_len_in;
   logic [31:0] body_start_ff, body_start_in;
   logic [63:0] pend_lo_ff, pend_lo_in;
   logic [15:0] pend_bits_ff, pend_bits_in;
   logic [15:0] acc_ch_ff, acc_ch_in;
   logic [31:0] acc_rate_ff, acc_rate_in;
   logic [15:0] acc_bits_ff, acc_bits_in;
   logic [31:0] data_off_ff, data_off_in;
   logic [31:0] data_size_ff, data_size_in;

   logic [31:0] base_pos;
   phase_type   base_phase;
   logic [63:0] shift_new;
   logic [31:0] pos_step;
   logic        do_finish;

   // A finished file still held for its result restarts from the reset state.
   assign base_pos   = final_ff ? '0 : pos_ff;
   assign base_phase = final_ff ? PHASE_RIFF : phase_ff;
   assign shift_new  = {file_byte, shift_ff[63:8]};
   assign pos_step   = (base_pos == '1) ? base_pos : base_pos + 32'd1;

   always_comb begin
      final_in      = final_ff;
      pos_in        = pos_ff;
      phase_in      = phase_ff;
      tag_error_in  = tag_error_ff;
      not_pcm_in    = not_pcm_ff;
      fmt_valid_in  = fmt_valid_ff;
      data_found_in = data_found_ff;
      shift_in      = shift_ff;
      remain_in     = remain_ff;
      kind_in       = kind_ff;
      body_idx_in   = body_idx_ff;
      chunk_len_in  = chunk_len_ff;
      body_start_in = body_start_ff;
      pend_lo_in    = pend_lo_ff;
      pend_bits_in  = pend_bits_ff;
      acc_ch_in     = acc_ch_ff;
      acc_rate_in   = acc_rate_ff;
      acc_bits_in   = acc_bits_ff;
      data_off_in   = data_off_ff;
      data_size_in  = data_size_ff;
      do_finish     = 1'b0;

      if (ctrl.take) begin
         final_in      = end_of_file;
         pos_in        = pos_step;
         phase_in      = base_phase;
         tag_error_in  = final_ff ? 1'b0 : tag_error_ff;
         not_pcm_in    = final_ff ? 1'b0 : not_pcm_ff;
         fmt_valid_in  = final_ff ? 1'b0 : fmt_valid_ff;
         data_found_in = final_ff ? 1'b0 : data_found_ff;

         unique case (base_phase)
            PHASE_RIFF: begin
               shift_in = shift_new;
               if (base_pos == 32'd3 && shift_new[63:32] != TAG_RIFF) begin
                  tag_error_in = 1'b1;
               end
               if (base_pos == 32'd11) begin
                  if (shift_new[63:32] != TAG_WAVE) begin
                     tag_error_in = 1'b1;
                  end
                  if (tag_error_in) begin
                     phase_in = PHASE_HALT;
                  end else begin
                     phase_in  = PHASE_CHDR;
                     remain_in = CHUNK_HEADER_BYTES;
                  end
               end
            end
            PHASE_CHDR: begin
               shift_in  = shift_new;
               remain_in = remain_ff - 32'd1;
               if (remain_ff == 32'd1) begin
                  chunk_len_in  = shift_new[63:32];
                  remain_in     = shift_new[63:32];
                  body_start_in = pos_step;
                  body_idx_in   = '0;
                  if (shift_new[31:0] == TAG_FMT) begin
                     kind_in = KIND_FMT;
                  end else if (shift_new[31:0] == TAG_DATA) begin
                     kind_in = KIND_DATA;
                  end else begin
                     kind_in = KIND_OTHER;
                  end
                  if (shift_new[63:32] == '0) begin
                     do_finish = 1'b1;
                  end else begin
                     phase_in = PHASE_BODY;
                  end
               end
            end
            PHASE_BODY: begin
               if (kind_ff == KIND_FMT && !body_idx_ff[4]) begin
                  if (!body_idx_ff[3]) begin
                     pend_lo_in[{body_idx_ff[2:0], 3'b000} +: 8] = file_byte;
                  end else if (body_idx_ff[2:0] == 3'd6) begin
                     pend_bits_in[7:0] = file_byte;
                  end else if (body_idx_ff[2:0] == 3'd7) begin
                     pend_bits_in[15:8] = file_byte;
                  end
               end
               if (!body_idx_ff[4]) begin
                  body_idx_in = body_idx_ff + 5'd1;
               end
               remain_in = remain_ff - 32'd1;
               if (remain_ff == 32'd1) begin
                  do_finish = 1'b1;
               end
            end
            PHASE_PAD: begin
               phase_in  = PHASE_CHDR;
               remain_in = CHUNK_HEADER_BYTES;
            end
            PHASE_HALT: begin
            end
            default: begin
               phase_in = PHASE_HALT;
            end
         endcase

         if (do_finish) begin
            if (kind_in == KIND_FMT) begin
               if (chunk_len_in < FMT_MIN_BYTES || pend_lo_in[15:0] != FORMAT_PCM) begin
                  not_pcm_in = 1'b1;
               end else begin
                  acc_ch_in    = pend_lo_in[31:16];
                  acc_rate_in  = pend_lo_in[63:32];
                  acc_bits_in  = pend_bits_in;
                  fmt_valid_in = 1'b1;
               end
            end else if (kind_in == KIND_DATA) begin
               data_found_in = 1'b1;
               data_off_in   = body_start_in;
               data_size_in  = chunk_len_in;
            end
            if (chunk_len_in[0]) begin
               phase_in = PHASE_PAD;
            end else begin
               phase_in  = PHASE_CHDR;
               remain_in = CHUNK_HEADER_BYTES;
            end
         end
      end else if (ctrl.form) begin
         final_in      = 1'b0;
         pos_in        = '0;
         phase_in      = PHASE_RIFF;
         tag_error_in  = 1'b0;
         not_pcm_in    = 1'b0;
         fmt_valid_in  = 1'b0;
         data_found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         final_ff      <= 1'b0;
         pos_ff        <= '0;
         phase_ff      <= PHASE_RIFF;
         tag_error_ff  <= 1'b0;
         not_pcm_ff    <= 1'b0;
         fmt_valid_ff  <= 1'b0;
         data_found_ff <= 1'b0;
      end else begin
         final_ff      <= final_in;
         pos_ff        <= pos_in;
         phase_ff      <= phase_in;
         tag_error_ff  <= tag_error_in;
         not_pcm_ff    <= not_pcm_in;
         fmt_valid_ff  <= fmt_valid_in;
         data_found_ff <= data_found_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff      <= shift_in;
      remain_ff     <= remain_in;
      kind_ff       <= kind_in;
      body_idx_ff   <= body_idx_in;
      chunk_len_ff  <= chunk_len_in;
      body_start_ff <= body_start_in;
      pend_lo_ff    <= pend_lo_in;
      pend_bits_ff  <= pend_bits_in;
      acc_ch_ff     <= acc_ch_in;
      acc_rate_ff   <= acc_rate_in;
      acc_bits_ff   <= acc_bits_in;
      data_off_ff   <= data_off_in;
      data_size_ff  <= data_size_in;
   end

   assign final_pending = final_ff;

   always_comb begin
      summary.length      = pos_ff;
      summary.tag_error   = tag_error_ff;
      summary.fmt_not_pcm = not_pcm_ff;
      summary.fmt_valid   = fmt_valid_ff;
      summary.channels    = acc_ch_ff;
      summary.rate        = acc_rate_ff;
      summary.bits        = acc_bits_ff;
      summary.data_found  = data_found_ff;
      summary.data_offset = data_off_ff;
      summary.data_size   = data_size_ff;
   end

   // A held file must not be overwritten by a new byte before its result is formed.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.take |-> (!final_ff || ctrl.form))
      else $error("Byte taken while a finished file awaits its result.");

   assert property (@(posedge clock) disable iff (reset)
      (ctrl.take && end_of_file) |=> final_ff)
      else $error("Last byte of a file did not mark the file as finished.");

   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PHASE_HALT) |-> tag_error_ff)
      else $error("Parser halted without a tag error.");

endmodule

`default_nettype wire

/* hw/rtl/wpp_result_former.sv */
// Forms the per-file result from the parse summary and holds it in the
// output register of the result channel. Depends on wpp_pkg and wpp_rsp_if.
`default_nettype none

module wpp_result_former import wpp_pkg::*; #(
   parameter int unsigned MIN_FILE_BYTES = MIN_FILE_BYTES_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            form,
   input  wire wpp_summary_type summary,
   output logic                 slot_free,
   wpp_rsp_if.source            rsp_chan
);

   logic           valid_ff, valid_in;
   wpp_status_type status_ff, status_c;
   logic [15:0]    channels_ff, channels_c;
   logic [30:0]    rate_ff, rate_c;
   logic [15:0]    bits_ff, bits_c;
   logic [1:0]     format_ff, format_c;
   logic [31:0]    offset_ff, offset_c;
   logic [31:0]    size_ff, size_c;

   logic [15:0] ch;
   logic [30:0] rate;
   logic [15:0] bits;
   logic [31:0] doff;
   logic [31:0] dsize;

   assign ch    = summary.fmt_valid ? summary.channels : '0;
   assign bits  = summary.fmt_valid ? summary.bits : '0;
   assign rate  = (summary.fmt_valid && !summary.rate[31]) ? summary.rate[30:0] : '0;
   assign doff  = summary.data_found ? summary.data_offset : '0;
   assign dsize = summary.data_found ? summary.data_size : '0;

   always_comb begin
      status_c   = STATUS_UNSUPPORTED;
      format_c   = '0;
      channels_c = ch;
      rate_c     = rate;
      bits_c     = bits;
      offset_c   = doff;
      size_c     = dsize;
      priority if (summary.length < 32'(MIN_FILE_BYTES)) begin
         status_c = STATUS_SHORT;
      end else if (summary.tag_error) begin
         status_c = STATUS_BAD_TAG;
      end else if (summary.fmt_not_pcm) begin
         status_c = STATUS_NOT_PCM;
      end else if (!summary.data_found || ch == '0 || bits == '0 || rate == '0) begin
         status_c = STATUS_MISSING;
      end else if ((ch == 16'd1 || ch == 16'd2) && (bits == 16'd8 || bits == 16'd16)) begin
         status_c = STATUS_OK;
         format_c = {ch == 16'd2, bits == 16'd16};
      end else begin
         status_c = STATUS_UNSUPPORTED;
      end
      if (status_c == STATUS_SHORT || status_c == STATUS_BAD_TAG ||
          status_c == STATUS_NOT_PCM) begin
         channels_c = '0;
         rate_c     = '0;
         bits_c     = '0;
         offset_c   = '0;
         size_c     = '0;
      end
   end

   assign slot_free = !valid_ff || rsp_chan.ready;
   assign valid_in  = form ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (form) begin
         status_ff   <= status_c;
         channels_ff <= channels_c;
         rate_ff     <= rate_c;
         bits_ff     <= bits_c;
         format_ff   <= format_c;
         offset_ff   <= offset_c;
         size_ff     <= size_c;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.status          = status_ff;
   assign rsp_chan.channel_count   = channels_ff;
   assign rsp_chan.sample_rate     = rate_ff;
   assign rsp_chan.bits_per_sample = bits_ff;
   assign rsp_chan.format_code     = format_ff;
   assign rsp_chan.data_offset     = offset_ff;
   assign rsp_chan.data_size       = size_ff;

   assert property (@(posedge clock) disable iff (reset)
      form |=> valid_ff)
      else $error("Formed result was not presented.");

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff == STATUS_OK) |->
         ((channels_ff == 16'd1 || channels_ff == 16'd2) &&
          (bits_ff == 16'd8 || bits_ff == 16'd16)))
      else $error("Result reported as good with an unsupported format.");

   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (status_ff == STATUS_SHORT || status_ff == STATUS_BAD_TAG ||
                    status_ff == STATUS_NOT_PCM)) |->
         (channels_ff == '0 && rate_ff == '0 && bits_ff == '0 &&
          offset_ff == '0 && size_ff == '0))
      else $error("Error result carries nonzero fields.");

endmodule

`default_nettype wire

/* hw/rtl/wav_pcm_header_parser_unit.sv */
// Throughput: one file byte per cycle while req_chan.ready is high; a result is registered once
// the last byte of its file has been taken and the result slot is free.
// The first byte of the following file waits only while an earlier result is not taken.
// Reset is synchronous and active high; it clears the parse state and the result valid.
// Depends on wpp_pkg, wpp_req_if, wpp_rsp_if, wpp_byte_parser and wpp_result_former.
`default_nettype none

module wav_pcm_header_parser_unit import wpp_pkg::*; #(
   parameter int unsigned MIN_FILE_BYTES = MIN_FILE_BYTES_DEFAULT
) (
   input wire logic  clock,
   input wire logic  reset,
   wpp_req_if.sink   req_chan,
   wpp_rsp_if.source rsp_chan
);

   wpp_ctrl_type    ctrl;
   wpp_summary_type summary;
   logic            final_pending;
   logic            slot_free;

   assign req_chan.ready = !final_pending || slot_free;
   assign ctrl           = '{take: req_chan.valid && req_chan.ready,
                             form: final_pending && slot_free};

   wpp_byte_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .file_byte     (req_chan.file_byte),
      .end_of_file   (req_chan.end_of_file),
      .summary       (summary),
      .final_pending (final_pending)
   );

   wpp_result_former #(
      .MIN_FILE_BYTES (MIN_FILE_BYTES)
   ) u_result (
      .clock     (clock),
      .reset     (reset),
      .form      (ctrl.form),
      .summary   (summary),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire
